### rtl/core/u2w_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package u2w_pkg;

    localparam int UNIT_W      = 21;
    localparam int BYTE_W      = 8;
    localparam int COUNT_W     = 3;
    localparam int OUT_TDATA_W = 24;

    localparam logic [UNIT_W-1:0] REPLACEMENT_UNIT = 21'h00FFFD;
    localparam logic [UNIT_W-1:0] HIGH_SURR_BASE   = 21'h00D800;
    localparam logic [UNIT_W-1:0] LOW_SURR_BASE    = 21'h00DC00;
    localparam logic [UNIT_W-1:0] PLANE_ONE        = 21'h010000;

    localparam logic WIDE_16BIT_RESET = 1'b1;

    // decoded work for one byte: n_rep replacement units, then unit_a, then unit_b
    typedef struct packed {
        logic [COUNT_W-1:0] total;
        logic [COUNT_W-1:0] n_rep;
        logic [UNIT_W-1:0]  unit_a;
        logic [UNIT_W-1:0]  unit_b;
    } desc_t;

endpackage

`default_nettype wire

### rtl/core/u2w_front.sv
`timescale 1ns / 1ps
`default_nettype none

module u2w_front
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           accept,
    input  wire logic [u2w_pkg::BYTE_W-1:0]     text_byte,
    input  wire logic                           end_of_text,
    input  wire logic                           wide_is_16bit,
    output logic                                push,
    output u2w_pkg::desc_t                      desc
);

    logic [u2w_pkg::UNIT_W-1:0]  acc_reg;
    logic [u2w_pkg::UNIT_W-1:0]  acc_next;
    logic [1:0]                  need_reg;
    logic [1:0]                  need_next;
    logic [1:0]                  held_reg;
    logic [1:0]                  held_next;
    logic [u2w_pkg::COUNT_W-1:0] n_rep;
    logic                        has_cp;
    logic [u2w_pkg::UNIT_W-1:0]  cp;
    logic                        pair;
    logic [u2w_pkg::UNIT_W-1:0]  v;
    logic                        is_cont;

    assign is_cont = (text_byte[7:6] == 2'b10);

    always_comb
    begin
        acc_next  = acc_reg;
        need_next = need_reg;
        held_next = held_reg;
        n_rep     = '0;
        has_cp    = 1'b0;
        cp        = '0;
        if (need_reg != 2'd0 && is_cont)
        begin
            acc_next  = {acc_reg[u2w_pkg::UNIT_W-7:0], text_byte[5:0]};
            need_next = need_reg - 2'd1;
            held_next = held_reg + 2'd1;
            if (need_next == 2'd0)
            begin
                has_cp    = 1'b1;
                cp        = acc_next;
                acc_next  = '0;
                held_next = 2'd0;
            end
        end
        else
        begin
            // broken sequence: one for the lead plus one per held continuation
            if (need_reg != 2'd0)
            begin
                n_rep = 3'd1 + {1'b0, held_reg};
            end
            acc_next  = '0;
            need_next = 2'd0;
            held_next = 2'd0;
            if (!text_byte[7])
            begin
                has_cp = 1'b1;
                cp     = {{(u2w_pkg::UNIT_W-u2w_pkg::BYTE_W){1'b0}}, text_byte};
            end
            else if (text_byte[7:5] == 3'b110)
            begin
                acc_next  = {{(u2w_pkg::UNIT_W-5){1'b0}}, text_byte[4:0]};
                need_next = 2'd1;
            end
            else if (text_byte[7:4] == 4'b1110)
            begin
                acc_next  = {{(u2w_pkg::UNIT_W-4){1'b0}}, text_byte[3:0]};
                need_next = 2'd2;
            end
            else if (text_byte[7:3] == 5'b11110)
            begin
                acc_next  = {{(u2w_pkg::UNIT_W-3){1'b0}}, text_byte[2:0]};
                need_next = 2'd3;
            end
            else
            begin
                n_rep = n_rep + 3'd1;
            end
        end
        // sequence cut off at end of text
        if (end_of_text && need_next != 2'd0)
        begin
            n_rep     = n_rep + 3'd1 + {1'b0, held_next};
            acc_next  = '0;
            need_next = 2'd0;
            held_next = 2'd0;
        end
    end

    assign v    = cp - u2w_pkg::PLANE_ONE;
    assign pair = has_cp && wide_is_16bit && (cp[u2w_pkg::UNIT_W-1:16] != '0);

    always_comb
    begin
        desc.n_rep  = n_rep;
        desc.total  = n_rep + {2'b00, has_cp} + {2'b00, pair};
        desc.unit_a = pair ? (u2w_pkg::HIGH_SURR_BASE + {10'd0, v[20:10]}) : cp;
        desc.unit_b = u2w_pkg::LOW_SURR_BASE + {11'd0, v[9:0]};
        push        = accept && (desc.total != '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg  <= '0;
            need_reg <= 2'd0;
            held_reg <= 2'd0;
        end
        else if (accept)
        begin
            acc_reg  <= acc_next;
            need_reg <= need_next;
            held_reg <= held_next;
        end
    end

endmodule

`default_nettype wire

### rtl/core/u2w_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module u2w_queue
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  push,
    input  wire u2w_pkg::desc_t        wr_desc,
    output logic                       full,
    input  wire logic                  pop,
    output logic                       valid,
    output u2w_pkg::desc_t             rd_desc
);

    u2w_pkg::desc_t entry_reg [2];
    logic           wr_ptr_reg;
    logic           rd_ptr_reg;
    logic [1:0]     count_reg;
    logic [1:0]     count_next;
    logic           do_push;
    logic           do_pop;

    assign do_push = push && (count_reg != 2'd2);
    assign do_pop  = pop && (count_reg != 2'd0);

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_comb
    begin
        full    = (count_reg == 2'd2);
        valid   = (count_reg != 2'd0);
        rd_desc = entry_reg[rd_ptr_reg];
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= wr_desc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

### rtl/core/u2w_back.sv
`timescale 1ns / 1ps
`default_nettype none

module u2w_back
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           head_valid,
    input  wire u2w_pkg::desc_t                 head_desc,
    output logic                                pop,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic [u2w_pkg::UNIT_W-1:0]          out_unit,
    output logic                                out_last
);

    logic [u2w_pkg::COUNT_W-1:0] idx_reg;
    logic                        valid_reg;
    logic [u2w_pkg::UNIT_W-1:0]  unit_reg;
    logic                        last_reg;
    logic                        load;
    logic                        is_last;
    logic [u2w_pkg::UNIT_W-1:0]  unit_sel;

    assign load    = head_valid && (!valid_reg || out_ready);
    assign is_last = (idx_reg == head_desc.total - 3'd1);
    assign pop     = load && is_last;

    always_comb
    begin
        if (idx_reg < head_desc.n_rep)
        begin
            unit_sel = u2w_pkg::REPLACEMENT_UNIT;
        end
        else if (idx_reg == head_desc.n_rep)
        begin
            unit_sel = head_desc.unit_a;
        end
        else
        begin
            unit_sel = head_desc.unit_b;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            unit_reg <= unit_sel;
            last_reg <= is_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                valid_reg <= 1'b1;
                idx_reg   <= is_last ? '0 : idx_reg + 3'd1;
            end
            else if (out_ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = valid_reg;
    assign out_unit  = unit_reg;
    assign out_last  = last_reg;

endmodule

`default_nettype wire

### rtl/core/utf8_to_wide_decoder.sv
// an accepted byte's descriptor goes into the two-entry queue, then each of its words
// is registered in the output stage; one byte per cycle in while the queue is not full, one
// word per cycle out while m_tready is high; a byte's entry is popped with its last word
// reset: rst_n asynchronous active low; clears the open sequence, queue and output,
// and sets wide_is_16bit to 1
`timescale 1ns / 1ps
`default_nettype none

module utf8_to_wide_decoder
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] text_byte
    input  wire logic        s_tlast,   // end_of_text
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // [20:0] wide_unit, [23:21] zero
    output logic             m_tlast,   // last_of_run
    input  wire logic        cfg_we,
    input  wire logic        cfg_wdata  // wide_is_16bit
);

    logic                        wide_reg;
    logic                        accept;
    logic                        push;
    u2w_pkg::desc_t              front_desc;
    u2w_pkg::desc_t              head_desc;
    logic                        q_full;
    logic                        head_valid;
    logic                        pop;
    logic [u2w_pkg::UNIT_W-1:0]  unit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wide_reg <= u2w_pkg::WIDE_16BIT_RESET;
        end
        else if (cfg_we)
        begin
            wide_reg <= cfg_wdata;
        end
    end

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    u2w_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .text_byte     (s_tdata),
        .end_of_text   (s_tlast),
        .wide_is_16bit (wide_reg),
        .push          (push),
        .desc          (front_desc)
    );

    u2w_queue u_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_desc (front_desc),
        .full    (q_full),
        .pop     (pop),
        .valid   (head_valid),
        .rd_desc (head_desc)
    );

    u2w_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_desc  (head_desc),
        .pop        (pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_unit   (unit),
        .out_last   (m_tlast)
    );

    assign m_tdata = {{(u2w_pkg::OUT_TDATA_W-u2w_pkg::UNIT_W){1'b0}}, unit};

endmodule

`default_nettype wire
